[hdl/grid_line_of_sight_top_assert.svh]
// ---------------------------------------------------------------------------
// Grid line-of-sight assertion macros
// Shared concurrent assertion forms, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef GRID_LINE_OF_SIGHT_TOP_ASSERT_SVH
`define GRID_LINE_OF_SIGHT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define GLOS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GLOS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GLOS_ASSERT_IMPL(lbl, ante, cons, msg)
`define GLOS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/glos_pkg.sv]
// ---------------------------------------------------------------------------
// Grid line-of-sight package
// Shared codes, types and helpers of the line-of-sight engine.
// ---------------------------------------------------------------------------
`default_nettype none

package glos_pkg;

    // doubled-resolution coordinate width (signed) and tile coordinate width (signed)
    localparam int CW = 9;
    localparam int TW = 8;
    // ray delta width and error accumulator width
    localparam int DW = 6;
    localparam int EW = 7;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_BEGIN  = 2'd1;
    localparam logic [1:0] FUNC_TRACE  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    localparam logic [6:0] MAP_WIDTH_RST  = 7'd64;
    localparam logic [6:0] MAP_HEIGHT_RST = 7'd64;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_P0,
        S_P1,
        S_EVAL,
        S_MRD0,
        S_MRD1,
        S_MCAP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic rd_en;
        logic wr_en;
    } t_mark_ctl;

    function automatic logic signed [TW-1:0] floor_half(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] s;
        s = v >>> 1;
        floor_half = s[TW-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/grid_line_of_sight_top.sv]
// ---------------------------------------------------------------------------
// Grid line-of-sight engine
// Tile transparency map, viewer, and corner ray tracing with visited marks.
// ---------------------------------------------------------------------------
// Requests are taken when start is high and busy is low; func selects load,
// begin or trace. Load and begin finish in the accept cycle.
// A trace runs a setup state (INIT), then for each ray step two map reads
// through the single map read port (P0, P1) and a compare (EVAL), then
// the mark row read-modify-write (MRD0, MRD1, MCAP), then an emit state
// per new tile. Ray steps are max(|2dx-1|, |2dy-1|), at most 17, and at
// most four tiles are emitted; busy is high until the last is registered.
// Each tile appears for one cycle on o_vis_x/o_vis_y with o_valid, o_last
// marking the final one; the receiver cannot stall. Map width and height
// sit at byte addresses 0 and 4 of the APB port; the user must write them
// only while idle; the block does not enforce it. Reset clears the viewer,
// visited marks and control state; the map stays undefined until loaded.
// ---------------------------------------------------------------------------
`default_nettype none

module grid_line_of_sight_top #(
    parameter int MAP_COLS    = 64,
    parameter int MAP_ROWS    = 64,
    parameter int VIEW_HALF_W = 8,
    parameter int VIEW_HALF_H = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        i_func,
    input  wire logic [5:0]        i_tile_x,
    input  wire logic [5:0]        i_tile_y,
    input  wire logic              i_transparent,
    input  wire logic signed [3:0] i_corner_dx,
    input  wire logic signed [3:0] i_corner_dy,
    output logic                   o_valid,
    output logic [5:0]             o_vis_x,
    output logic [5:0]             o_vis_y,
    output logic                   o_last,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int MAP_DEPTH = MAP_COLS * MAP_ROWS;
    localparam int MAW       = $clog2(MAP_DEPTH);
    localparam int ROWS      = 2 * VIEW_HALF_W + 1;
    localparam int RBITS     = 2 * VIEW_HALF_H + 1;
    localparam int RIW       = $clog2(ROWS);

    logic [6:0] r_map_width, r_map_height;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= glos_pkg::MAP_WIDTH_RST;
            r_map_height <= glos_pkg::MAP_HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                glos_pkg::REG_MAP_WIDTH:  r_map_width  <= pwdata[6:0];
                glos_pkg::REG_MAP_HEIGHT: r_map_height <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    assign prdata = {25'd0, (paddr[2] == glos_pkg::REG_MAP_HEIGHT) ? r_map_height
                                                                   : r_map_width};

    logic                map_wr_en, map_wr_data, map_rd_en, map_rd_data;
    logic [MAW-1:0]      map_wr_addr, map_rd_addr;
    glos_pkg::t_mark_ctl mark_ctl;
    logic [RIW-1:0]      mark_rd_idx, mark_wr_idx;
    logic [RBITS-1:0]    mark_wr_data, mark_rd_data;

    glos_map_mem #(
        .DEPTH (MAP_DEPTH),
        .AW    (MAW)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (map_wr_en),
        .i_wr_addr (map_wr_addr),
        .i_wr_data (map_wr_data),
        .i_rd_en   (map_rd_en),
        .i_rd_addr (map_rd_addr),
        .o_rd_data (map_rd_data)
    );

    glos_mark_mem #(
        .ROWS  (ROWS),
        .RBITS (RBITS),
        .RIW   (RIW)
    ) u_mark (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mark_ctl),
        .i_rd_idx  (mark_rd_idx),
        .i_wr_idx  (mark_wr_idx),
        .i_wr_data (mark_wr_data),
        .o_rd_data (mark_rd_data)
    );

    glos_ctrl #(
        .MAP_COLS    (MAP_COLS),
        .MAP_ROWS    (MAP_ROWS),
        .VIEW_HALF_W (VIEW_HALF_W),
        .VIEW_HALF_H (VIEW_HALF_H),
        .MAW         (MAW),
        .RBITS       (RBITS),
        .RIW         (RIW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_func         (i_func),
        .i_tile_x       (i_tile_x),
        .i_tile_y       (i_tile_y),
        .i_transparent  (i_transparent),
        .i_corner_dx    (i_corner_dx),
        .i_corner_dy    (i_corner_dy),
        .i_map_width    (r_map_width),
        .i_map_height   (r_map_height),
        .i_map_rd_data  (map_rd_data),
        .i_mark_rd_data (mark_rd_data),
        .o_busy         (busy),
        .o_map_wr_en    (map_wr_en),
        .o_map_wr_addr  (map_wr_addr),
        .o_map_wr_data  (map_wr_data),
        .o_map_rd_en    (map_rd_en),
        .o_map_rd_addr  (map_rd_addr),
        .o_mark_ctl     (mark_ctl),
        .o_mark_rd_idx  (mark_rd_idx),
        .o_mark_wr_idx  (mark_wr_idx),
        .o_mark_wr_data (mark_wr_data),
        .o_valid        (o_valid),
        .o_vis_x        (o_vis_x),
        .o_vis_y        (o_vis_y),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

[hdl/glos_map_mem.sv]
// ---------------------------------------------------------------------------
// Transparency map memory
// One bit per tile, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module glos_map_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic          i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic               o_rd_data
);

    logic mem [DEPTH];
    logic r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hdl/glos_mark_mem.sv]
// ---------------------------------------------------------------------------
// Visited mark memory
// One row of marks per view column, with a valid flop per row so a begin
// request clears the whole store at once.
// ---------------------------------------------------------------------------
`default_nettype none

module glos_mark_mem #(
    parameter int ROWS  = 17,
    parameter int RBITS = 17,
    parameter int RIW   = 5
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire glos_pkg::t_mark_ctl i_ctl,
    input  wire logic [RIW-1:0]     i_rd_idx,
    input  wire logic [RIW-1:0]     i_wr_idx,
    input  wire logic [RBITS-1:0]   i_wr_data,
    output logic [RBITS-1:0]        o_rd_data
);

    logic [RBITS-1:0] mem [ROWS];
    logic [ROWS-1:0]  r_row_valid;
    logic [RBITS-1:0] r_rd_data;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_ctl.clear) begin
            r_row_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_row_valid[i_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data  <= mem[i_rd_idx];
            r_rd_valid <= r_row_valid[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

[hdl/glos_ctrl.sv]
// ---------------------------------------------------------------------------
// Line-of-sight sequencer
// Decodes requests, walks the ray one step at a time against the map memory,
// then reads, marks and writes back the two mark rows and emits new tiles.
// ---------------------------------------------------------------------------
`default_nettype none
`include "grid_line_of_sight_top_assert.svh"

module glos_ctrl #(
    parameter int MAP_COLS    = 64,
    parameter int MAP_ROWS    = 64,
    parameter int VIEW_HALF_W = 8,
    parameter int VIEW_HALF_H = 8,
    parameter int MAW         = 12,
    parameter int RBITS       = 17,
    parameter int RIW         = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [1:0]        i_func,
    input  wire logic [5:0]        i_tile_x,
    input  wire logic [5:0]        i_tile_y,
    input  wire logic              i_transparent,
    input  wire logic signed [3:0] i_corner_dx,
    input  wire logic signed [3:0] i_corner_dy,
    input  wire logic [6:0]        i_map_width,
    input  wire logic [6:0]        i_map_height,
    input  wire logic              i_map_rd_data,
    input  wire logic [RBITS-1:0]  i_mark_rd_data,
    output logic                   o_busy,
    output logic                   o_map_wr_en,
    output logic [MAW-1:0]         o_map_wr_addr,
    output logic                   o_map_wr_data,
    output logic                   o_map_rd_en,
    output logic [MAW-1:0]         o_map_rd_addr,
    output glos_pkg::t_mark_ctl    o_mark_ctl,
    output logic [RIW-1:0]         o_mark_rd_idx,
    output logic [RIW-1:0]         o_mark_wr_idx,
    output logic [RBITS-1:0]       o_mark_wr_data,
    output logic                   o_valid,
    output logic [5:0]             o_vis_x,
    output logic [5:0]             o_vis_y,
    output logic                   o_last
);

    localparam int CW  = glos_pkg::CW;
    localparam int TW  = glos_pkg::TW;
    localparam int DW  = glos_pkg::DW;
    localparam int EW  = glos_pkg::EW;
    localparam int RBW = $clog2(RBITS);

    glos_pkg::t_state r_state, n_state;

    logic [5:0]              r_vc, r_vr;
    logic signed [3:0]       r_dx, r_dy;
    logic signed [TW-1:0]    r_cc, r_cr;
    logic signed [CW-1:0]    r_m, r_n, r_mt;
    logic [EW-1:0]           r_err;
    logic [DW-1:0]           r_dmaj, r_dmin;
    logic                    r_xmaj, r_inc_neg, r_step_neg, r_step_z;
    logic                    r_in0, r_in1, r_c0;
    logic [3:0]              r_pend;
    logic                    r_valid, r_last;
    logic [5:0]              r_vis_x, r_vis_y;

    function automatic logic f_in_map(input logic signed [TW-1:0] x,
                                      input logic signed [TW-1:0] y,
                                      input logic [6:0] w, input logic [6:0] h);
        f_in_map = !x[TW-1] && !y[TW-1] && (int'(x) < int'(w)) && (int'(x) < MAP_COLS) &&
                   (int'(y) < int'(h)) && (int'(y) < MAP_ROWS);
    endfunction

    function automatic logic [MAW-1:0] f_addr(input logic signed [TW-1:0] x,
                                              input logic signed [TW-1:0] y);
        f_addr = MAW'(x[TW-2:0]) * MAW'(MAP_ROWS) + MAW'(y[TW-2:0]);
    endfunction

    logic accept;
    assign accept = i_start && (r_state == glos_pkg::S_IDLE);

    // trace setup
    logic signed [TW-1:0] w_cc, w_cr;
    logic signed [CW-1:0] w_sx, w_sy, w_tx, w_ty, w_ddx, w_ddy;
    logic [DW-1:0]        w_adx, w_ady;
    logic                 w_xmaj, w_trace_ok;

    always_comb begin
        w_cc  = $signed({2'b00, r_vc}) + TW'(r_dx);
        w_cr  = $signed({2'b00, r_vr}) + TW'(r_dy);
        w_sx  = $signed({2'b00, r_vc, 1'b1});
        w_sy  = $signed({2'b00, r_vr, 1'b1});
        w_tx  = $signed({w_cc, 1'b0});
        w_ty  = $signed({w_cr, 1'b0});
        w_ddx = w_tx - w_sx;
        w_ddy = w_ty - w_sy;
        w_adx = w_ddx[CW-1] ? DW'(-w_ddx) : DW'(w_ddx);
        w_ady = w_ddy[CW-1] ? DW'(-w_ddy) : DW'(w_ddy);
        w_xmaj = w_adx > w_ady;
        w_trace_ok = !(int'(r_dx) < -VIEW_HALF_W || int'(r_dx) >= VIEW_HALF_W ||
                       int'(r_dy) < -VIEW_HALF_H || int'(r_dy) >= VIEW_HALF_H) &&
                     f_in_map(w_cc, w_cr, i_map_width, i_map_height);
    end

    // ray probe points
    logic                 p_corner, p_blocked, p_done;
    logic signed [CW-1:0] incv, stepv, pm, pn, px2, py2, m_next;
    logic signed [TW-1:0] ptx, pty;
    logic [EW-1:0]        err_sum;
    logic                 c1;

    always_comb begin
        incv  = r_inc_neg ? -CW'(1) : CW'(1);
        stepv = r_step_z ? '0 : (r_step_neg ? -CW'(1) : CW'(1));
        p_corner = !r_m[0] && !r_n[0];
        pm = r_m;
        pn = r_n;
        if (p_corner) begin
            if (r_state == glos_pkg::S_P1) begin
                pn = r_n + stepv;
            end else begin
                pm = r_m + incv;
            end
        end else if (!r_m[0]) begin
            pm = (r_state == glos_pkg::S_P1) ? r_m + incv : r_m - incv;
        end else if (!r_n[0]) begin
            pn = (r_state == glos_pkg::S_P1) ? r_n + stepv : r_n - stepv;
        end
        px2 = r_xmaj ? pm : pn;
        py2 = r_xmaj ? pn : pm;
        ptx = glos_pkg::floor_half(px2);
        pty = glos_pkg::floor_half(py2);
        c1  = r_in1 && i_map_rd_data;
        p_blocked = p_corner ? (!r_c0 && !c1) : (!r_c0 || !c1);
        m_next  = r_m + incv;
        err_sum = r_err + EW'(r_dmin);
        p_done  = (m_next == r_mt);
    end

    // mark rows and emits
    logic [RIW-1:0]   row0, row1;
    logic [RBW-1:0]   oy0, oy1;
    logic [RBITS-1:0] oh0, oh1;
    logic             e_a, e_b;
    logic signed [TW-1:0] cm1, rm1;
    logic [1:0]       k;
    logic [3:0]       pend_clr;

    always_comb begin
        row0 = RIW'(int'(r_dx) + VIEW_HALF_W);
        row1 = RIW'(int'(r_dx) + VIEW_HALF_W + 1);
        oy0  = RBW'(int'(r_dy) + VIEW_HALF_H);
        oy1  = RBW'(int'(r_dy) + VIEW_HALF_H + 1);
        oh0  = RBITS'(1) << oy0;
        oh1  = RBITS'(1) << oy1;
        cm1  = r_cc - TW'(1);
        rm1  = r_cr - TW'(1);
        e_a  = !i_mark_rd_data[oy0] &&
               f_in_map((r_state == glos_pkg::S_MCAP) ? r_cc : cm1, rm1,
                        i_map_width, i_map_height);
        e_b  = !i_mark_rd_data[oy1] &&
               f_in_map((r_state == glos_pkg::S_MCAP) ? r_cc : cm1, r_cr,
                        i_map_width, i_map_height);
        if (r_pend[0]) begin
            k = 2'd0;
        end else if (r_pend[1]) begin
            k = 2'd1;
        end else if (r_pend[2]) begin
            k = 2'd2;
        end else begin
            k = 2'd3;
        end
        pend_clr = r_pend & ~(4'b0001 << k);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            glos_pkg::S_IDLE: begin
                if (accept && i_func == glos_pkg::FUNC_TRACE) begin
                    n_state = glos_pkg::S_INIT;
                end
            end
            glos_pkg::S_INIT: n_state = w_trace_ok ? glos_pkg::S_P0 : glos_pkg::S_IDLE;
            glos_pkg::S_P0:   n_state = glos_pkg::S_P1;
            glos_pkg::S_P1:   n_state = glos_pkg::S_EVAL;
            glos_pkg::S_EVAL: begin
                if (p_blocked) begin
                    n_state = glos_pkg::S_IDLE;
                end else if (p_done) begin
                    n_state = glos_pkg::S_MRD0;
                end else begin
                    n_state = glos_pkg::S_P0;
                end
            end
            glos_pkg::S_MRD0: n_state = glos_pkg::S_MRD1;
            glos_pkg::S_MRD1: n_state = glos_pkg::S_MCAP;
            glos_pkg::S_MCAP: begin
                n_state = ({e_b, e_a, r_pend[1:0]} == 4'b0000) ? glos_pkg::S_IDLE
                                                             : glos_pkg::S_EMIT;
            end
            glos_pkg::S_EMIT: n_state = (pend_clr == 4'b0000) ? glos_pkg::S_IDLE
                                                              : glos_pkg::S_EMIT;
            default: n_state = glos_pkg::S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        o_map_wr_en   = accept && i_func == glos_pkg::FUNC_LOAD &&
                        int'(i_tile_x) < MAP_COLS && int'(i_tile_y) < MAP_ROWS;
        o_map_wr_addr = f_addr($signed({2'b00, i_tile_x}), $signed({2'b00, i_tile_y}));
        o_map_wr_data = i_transparent;
        o_map_rd_en   = 1'b0;
        o_map_rd_addr = f_addr(ptx, pty);
        o_mark_ctl    = '0;
        o_mark_rd_idx = row0;
        o_mark_wr_idx = row0;
        o_mark_wr_data = i_mark_rd_data | (e_a ? oh0 : '0) | (e_b ? oh1 : '0);
        unique case (r_state)
            glos_pkg::S_IDLE: o_mark_ctl.clear = accept && i_func == glos_pkg::FUNC_BEGIN;
            glos_pkg::S_P0,
            glos_pkg::S_P1:   o_map_rd_en = 1'b1;
            glos_pkg::S_MRD0: o_mark_ctl.rd_en = 1'b1;
            glos_pkg::S_MRD1: begin
                o_mark_ctl.rd_en = 1'b1;
                o_mark_ctl.wr_en = 1'b1;
                o_mark_rd_idx    = row1;
            end
            glos_pkg::S_MCAP: begin
                o_mark_ctl.wr_en = 1'b1;
                o_mark_wr_idx    = row1;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= glos_pkg::S_IDLE;
            r_vc    <= '0;
            r_vr    <= '0;
            r_pend  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == glos_pkg::S_EMIT);
            if (accept && i_func == glos_pkg::FUNC_BEGIN) begin
                r_vc <= i_tile_x;
                r_vr <= i_tile_y;
            end
            unique case (r_state)
                glos_pkg::S_INIT: r_pend <= '0;
                glos_pkg::S_MRD1: r_pend[1:0] <= {e_b, e_a};
                glos_pkg::S_MCAP: r_pend[3:2] <= {e_b, e_a};
                glos_pkg::S_EMIT: r_pend <= pend_clr;
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dx <= i_corner_dx;
            r_dy <= i_corner_dy;
        end
        unique case (r_state)
            glos_pkg::S_INIT: begin
                r_cc       <= w_cc;
                r_cr       <= w_cr;
                r_xmaj     <= w_xmaj;
                r_m        <= w_xmaj ? w_sx : w_sy;
                r_n        <= w_xmaj ? w_sy : w_sx;
                r_mt       <= w_xmaj ? w_tx : w_ty;
                r_dmaj     <= w_xmaj ? w_adx : w_ady;
                r_dmin     <= w_xmaj ? w_ady : w_adx;
                r_inc_neg  <= w_xmaj ? w_ddx[CW-1] : w_ddy[CW-1];
                r_step_neg <= w_xmaj ? w_ddy[CW-1] : w_ddx[CW-1];
                r_step_z   <= w_xmaj ? (w_ady == '0) : (w_adx == '0);
                r_err      <= '0;
            end
            glos_pkg::S_P0: r_in0 <= f_in_map(ptx, pty, i_map_width, i_map_height);
            glos_pkg::S_P1: begin
                r_c0  <= r_in0 && i_map_rd_data;
                r_in1 <= f_in_map(ptx, pty, i_map_width, i_map_height);
            end
            glos_pkg::S_EVAL: begin
                r_m <= m_next;
                if (err_sum >= EW'(r_dmaj)) begin
                    r_n   <= r_n + stepv;
                    r_err <= err_sum - EW'(r_dmaj);
                end else begin
                    r_err <= err_sum;
                end
            end
            glos_pkg::S_EMIT: begin
                r_vis_x <= k[1] ? r_cc[5:0] : cm1[5:0];
                r_vis_y <= k[0] ? r_cr[5:0] : rm1[5:0];
                r_last  <= (pend_clr == 4'b0000);
            end
            default: ;
        endcase
    end

    assign o_busy  = (r_state != glos_pkg::S_IDLE);
    assign o_valid = r_valid;
    assign o_vis_x = r_vis_x;
    assign o_vis_y = r_vis_y;
    assign o_last  = r_last;

    `GLOS_ASSERT_IMPL(a_emit_src, r_valid, $past(r_state) == glos_pkg::S_EMIT, "result without emit")
    `GLOS_ASSERT_NEXT(a_last_ends, r_valid && r_last, !r_valid, "result after last")
    `GLOS_ASSERT_IMPL(a_mark_rw, o_mark_ctl.wr_en && o_mark_ctl.rd_en,
                      o_mark_wr_idx != o_mark_rd_idx, "mark row read and write collide")
    `GLOS_ASSERT_IMPL(a_idle_pend, r_state == glos_pkg::S_IDLE, r_pend == 4'b0000,
                      "pending tiles left while idle")

endmodule

`default_nettype wire
